@@ hdl/cau_pkg.sv @@
package cau_pkg;

    // Operand format: signed fixed point, DATA_WIDTH bits with FRAC_BITS fraction bits
    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 8;

    // Widths of products, sums and the divider remainder
    localparam int PW = 2 * DATA_WIDTH;
    localparam int SW = PW + 1;
    localparam int RW = PW + DATA_WIDTH;

    // Saturation limits as magnitudes
    localparam logic [PW-1:0] POS_LIMIT = PW'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
    localparam logic [PW-1:0] NEG_LIMIT = PW'(64'd1 << (DATA_WIDTH - 1));

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } cau_op_t;

    typedef struct packed {
        cau_op_t                       kind;
        logic signed [DATA_WIDTH-1:0]  a_re;
        logic signed [DATA_WIDTH-1:0]  a_im;
        logic signed [DATA_WIDTH-1:0]  b_re;
        logic signed [DATA_WIDTH-1:0]  b_im;
    } cau_req_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0]  res_re;
        logic signed [DATA_WIDTH-1:0]  res_im;
        logic                          overflow;
        logic                          div_zero;
    } cau_rsp_t;

    // Per-item control carried down the pipeline
    typedef struct packed {
        cau_op_t op;
        logic    dz;
    } cau_ctrl_t;

    // One result part in sign-magnitude form, with divider working state
    typedef struct packed {
        logic                   neg;
        logic                   big;
        logic [RW-1:0]          rem;
        logic [DATA_WIDTH-1:0]  quo;
    } cau_lane_t;

endpackage

@@ hdl/cau_front.sv @@
module cau_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               req_valid,
    input  cau_pkg::cau_req_t  req,
    output logic               valid,
    output cau_pkg::cau_ctrl_t ctrl,
    output cau_pkg::cau_lane_t lane_re,
    output cau_pkg::cau_lane_t lane_im,
    output logic [cau_pkg::PW-1:0] den
);
    import cau_pkg::*;

    // Stage 1: operand capture
    logic     s1_valid_reg;
    cau_req_t s1_req_reg;

    // Stage 2: products
    logic                 s2_valid_reg;
    cau_req_t             s2_req_reg;
    logic signed [PW-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, p_dr_reg, p_di_reg;

    // Stage 3: sums in sign-magnitude
    logic      s3_valid_reg;
    cau_ctrl_t s3_ctrl_reg;
    cau_lane_t s3_re_reg, s3_im_reg;
    logic [PW-1:0] s3_den_reg;

    logic signed [SW-1:0] sum_re, sum_im;
    logic [PW-1:0]        mag_re, mag_im, den_sum;
    cau_ctrl_t            ctrl_next;
    cau_lane_t            re_next, im_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= req_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_req_reg  <= req;
            s2_req_reg  <= s1_req_reg;
            p_rr_reg    <= PW'(s1_req_reg.a_re) * PW'(s1_req_reg.b_re);
            p_ii_reg    <= PW'(s1_req_reg.a_im) * PW'(s1_req_reg.b_im);
            p_ri_reg    <= PW'(s1_req_reg.a_re) * PW'(s1_req_reg.b_im);
            p_ir_reg    <= PW'(s1_req_reg.a_im) * PW'(s1_req_reg.b_re);
            p_dr_reg    <= PW'(s1_req_reg.b_re) * PW'(s1_req_reg.b_re);
            p_di_reg    <= PW'(s1_req_reg.b_im) * PW'(s1_req_reg.b_im);
            s3_ctrl_reg <= ctrl_next;
            s3_re_reg   <= re_next;
            s3_im_reg   <= im_next;
            s3_den_reg  <= den_sum;
        end
    end

    // Select the two sums for the operation
    always_comb
    begin
        case (s2_req_reg.kind)
            OP_ADD:
            begin
                sum_re = SW'(s2_req_reg.a_re) + SW'(s2_req_reg.b_re);
                sum_im = SW'(s2_req_reg.a_im) + SW'(s2_req_reg.b_im);
            end
            OP_SUB:
            begin
                sum_re = SW'(s2_req_reg.a_re) - SW'(s2_req_reg.b_re);
                sum_im = SW'(s2_req_reg.a_im) - SW'(s2_req_reg.b_im);
            end
            OP_MUL:
            begin
                sum_re = SW'(p_rr_reg) - SW'(p_ii_reg);
                sum_im = SW'(p_ri_reg) + SW'(p_ir_reg);
            end
            default:
            begin
                sum_re = SW'(p_rr_reg) + SW'(p_ii_reg);
                sum_im = SW'(p_ir_reg) - SW'(p_ri_reg);
            end
        endcase
    end

    // Magnitudes; multiply drops the extra fraction bits here
    always_comb
    begin
        mag_re  = sum_re[SW-1] ? PW'(-sum_re) : PW'(sum_re);
        mag_im  = sum_im[SW-1] ? PW'(-sum_im) : PW'(sum_im);
        den_sum = p_dr_reg[PW-1:0] + p_di_reg[PW-1:0];
        if (s2_req_reg.kind == OP_MUL)
        begin
            mag_re = mag_re >> FRAC_BITS;
            mag_im = mag_im >> FRAC_BITS;
        end
        ctrl_next.op = s2_req_reg.kind;
        ctrl_next.dz = (s2_req_reg.kind == OP_DIV) && (den_sum == '0);
        re_next.neg  = sum_re[SW-1];
        re_next.big  = 1'b0;
        re_next.rem  = RW'(mag_re);
        re_next.quo  = '0;
        im_next.neg  = sum_im[SW-1];
        im_next.big  = 1'b0;
        im_next.rem  = RW'(mag_im);
        im_next.quo  = '0;
    end

    assign valid   = s3_valid_reg;
    assign ctrl    = s3_ctrl_reg;
    assign lane_re = s3_re_reg;
    assign lane_im = s3_im_reg;
    assign den     = s3_den_reg;

endmodule

@@ hdl/cau_divider.sv @@
module cau_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               valid_in,
    input  cau_pkg::cau_ctrl_t ctrl_in,
    input  cau_pkg::cau_lane_t re_in,
    input  cau_pkg::cau_lane_t im_in,
    input  logic [cau_pkg::PW-1:0] den_in,
    output logic               valid_out,
    output cau_pkg::cau_ctrl_t ctrl_out,
    output cau_pkg::cau_lane_t re_out,
    output cau_pkg::cau_lane_t im_out
);
    import cau_pkg::*;

    localparam int NST = DATA_WIDTH + 1;

    // Stage 0 prepares the numerator, stages 1..DATA_WIDTH retire one quotient bit each
    logic          st_valid_reg [NST];
    cau_ctrl_t     st_ctrl_reg  [NST];
    cau_lane_t     st_re_reg    [NST];
    cau_lane_t     st_im_reg    [NST];
    logic [PW-1:0] st_den_reg   [NST];

    // Flag quotients of 2^DATA_WIDTH or more, then scale the numerator
    function automatic cau_lane_t prep(cau_lane_t l, logic [PW-1:0] d, logic is_div);
        cau_lane_t r;
        r = l;
        if (is_div)
        begin
            r.big = l.rem >= (RW'(d) << (DATA_WIDTH - FRAC_BITS));
            r.rem = l.rem << FRAC_BITS;
        end
        return r;
    endfunction

    // One restoring step at quotient bit idx
    function automatic cau_lane_t step(cau_lane_t l, logic [PW-1:0] d, int idx, logic is_div);
        cau_lane_t     r;
        logic [RW-1:0] sh;
        r  = l;
        sh = RW'(d) << idx;
        if (is_div && !l.big && (l.rem >= sh))
        begin
            r.rem      = l.rem - sh;
            r.quo[idx] = 1'b1;
        end
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            st_valid_reg[0] <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_ctrl_reg[0] <= ctrl_in;
            st_re_reg[0]   <= prep(re_in, den_in, ctrl_in.op == OP_DIV);
            st_im_reg[0]   <= prep(im_in, den_in, ctrl_in.op == OP_DIV);
            st_den_reg[0]  <= den_in;
        end
    end

    for (genvar k = 1; k < NST; k++)
    begin : g_step
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                st_valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                st_valid_reg[k] <= st_valid_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_ctrl_reg[k] <= st_ctrl_reg[k-1];
                st_den_reg[k]  <= st_den_reg[k-1];
                st_re_reg[k]   <= step(st_re_reg[k-1], st_den_reg[k-1], DATA_WIDTH - k,
                                       st_ctrl_reg[k-1].op == OP_DIV);
                st_im_reg[k]   <= step(st_im_reg[k-1], st_den_reg[k-1], DATA_WIDTH - k,
                                       st_ctrl_reg[k-1].op == OP_DIV);
            end
        end
    end

    assign valid_out = st_valid_reg[NST-1];
    assign ctrl_out  = st_ctrl_reg[NST-1];
    assign re_out    = st_re_reg[NST-1];
    assign im_out    = st_im_reg[NST-1];

endmodule

@@ hdl/cau_back.sv @@
module cau_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               valid_in,
    input  cau_pkg::cau_ctrl_t ctrl_in,
    input  cau_pkg::cau_lane_t re_in,
    input  cau_pkg::cau_lane_t im_in,
    output logic               rsp_valid,
    output cau_pkg::cau_rsp_t  rsp
);
    import cau_pkg::*;

    logic     rsp_valid_reg;
    cau_rsp_t rsp_reg;
    cau_rsp_t rsp_next;

    // Final magnitude of one part
    function automatic logic [PW-1:0] final_mag(cau_lane_t l, logic is_div);
        logic [PW-1:0] m;
        if (is_div)
        begin
            m = l.big ? (PW'(1) << DATA_WIDTH) : PW'(l.quo);
        end
        else
        begin
            m = l.rem[PW-1:0];
        end
        return m;
    endfunction

    // Saturate and return {overflow, value}
    function automatic logic [DATA_WIDTH:0] pack(logic neg, logic [PW-1:0] m);
        logic [PW-1:0] t;
        logic          ov;
        t  = m;
        ov = 1'b0;
        if (!neg && (m > POS_LIMIT))
        begin
            t  = POS_LIMIT;
            ov = 1'b1;
        end
        else if (neg && (m > NEG_LIMIT))
        begin
            t  = NEG_LIMIT;
            ov = 1'b1;
        end
        if (neg)
        begin
            t = -t;
        end
        return {ov, t[DATA_WIDTH-1:0]};
    endfunction

    always_comb
    begin
        logic [DATA_WIDTH:0] pr;
        logic [DATA_WIDTH:0] pi;
        pr = pack(re_in.neg, final_mag(re_in, ctrl_in.op == OP_DIV));
        pi = pack(im_in.neg, final_mag(im_in, ctrl_in.op == OP_DIV));
        rsp_next.res_re   = pr[DATA_WIDTH-1:0];
        rsp_next.res_im   = pi[DATA_WIDTH-1:0];
        rsp_next.overflow = pr[DATA_WIDTH] | pi[DATA_WIDTH];
        rsp_next.div_zero = 1'b0;
        if (ctrl_in.dz)
        begin
            rsp_next.res_re   = '0;
            rsp_next.res_im   = '0;
            rsp_next.overflow = 1'b0;
            rsp_next.div_zero = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            rsp_valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ hdl/complex_arith_unit.sv @@
// Complex arithmetic unit: add, subtract, multiply or divide two signed Q8.8
// complex operands per transfer.
// Request channel: req_valid, req_stall, req (kind and both operands). A
// transfer happens on a rising edge with req_valid high and req_stall low.
// Response channel: rsp_valid, rsp_stall, rsp (result parts, overflow,
// div_zero). Exactly one response per request, in order.
// Depth: 21 register stages from the request transfer to rsp_valid.
// Throughput: one transfer per cycle while rsp_stall holds no response. The
// depth is set by the divider, which resolves one quotient bit per stage,
// after three stages of operand capture, products and sums, and one stage
// of numerator setup.
// Results saturate to 0x7FFF / 0x8000 with overflow set; products and
// quotients truncate toward zero. A divide by zero returns 0 with div_zero.
// Reset clears every valid bit; the pipeline comes up empty.
// When rsp_stall holds a pending response, the whole pipeline freezes and
// req_stall is raised in the same cycle; nothing is lost or repeated.
module complex_arith_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  cau_pkg::cau_req_t  req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output cau_pkg::cau_rsp_t  rsp
);
    import cau_pkg::*;

    logic          en;
    logic          f_valid, d_valid;
    cau_ctrl_t     f_ctrl, d_ctrl;
    cau_lane_t     f_re, f_im, d_re, d_im;
    logic [PW-1:0] f_den;

    // Global advance: hold everything while a response waits
    assign en        = !(rsp_valid && rsp_stall);
    assign req_stall = !en;

    cau_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .req_valid (req_valid),
        .req       (req),
        .valid     (f_valid),
        .ctrl      (f_ctrl),
        .lane_re   (f_re),
        .lane_im   (f_im),
        .den       (f_den)
    );

    cau_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (f_valid),
        .ctrl_in   (f_ctrl),
        .re_in     (f_re),
        .im_in     (f_im),
        .den_in    (f_den),
        .valid_out (d_valid),
        .ctrl_out  (d_ctrl),
        .re_out    (d_re),
        .im_out    (d_im)
    );

    cau_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (d_valid),
        .ctrl_in   (d_ctrl),
        .re_in     (d_re),
        .im_in     (d_im),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

    // Divide by zero gives a clean zero result
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.div_zero |->
            rsp.res_re == '0 && rsp.res_im == '0 && !rsp.overflow)
        else $error("div_zero response carries nonzero data");

    // Request stall comes only from a held response
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> rsp_valid && rsp_stall)
        else $error("request stalled without response backpressure");

    // Overflow means at least one part sits at a rail
    a_ov_rail: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.overflow |->
            rsp.res_re == DATA_WIDTH'(POS_LIMIT) || rsp.res_re == DATA_WIDTH'(NEG_LIMIT) ||
            rsp.res_im == DATA_WIDTH'(POS_LIMIT) || rsp.res_im == DATA_WIDTH'(NEG_LIMIT))
        else $error("overflow without saturated part");

endmodule
